// File: hdl/bitmap_slot_allocator_defines.svh
// assertion macros for the slot allocator
`ifndef BITMAP_SLOT_ALLOCATOR_DEFINES_SVH
`define BITMAP_SLOT_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off while rst_n is low
`define BSA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bitmap slot allocator check failed");
// next-cycle implication, sampled on clk, off while rst_n is low
`define BSA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bitmap slot allocator check failed");
`else
`define BSA_ASSERT_NOW(lbl, ante, cons)
`define BSA_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: hdl/bsa_pkg.sv
package bsa_pkg;

  // geometry; WORD_BITS is a power of two so a slot splits into word and bit
  localparam int ENTRIES    = 256;
  localparam int WORD_BITS  = 32;
  localparam int NWORDS     = (ENTRIES + WORD_BITS - 1) / WORD_BITS;
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int WORD_AW    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int SLOT_IN_W  = 8;
  localparam int SLOT_OUT_W = 8;
  localparam int COUNT_W    = 9;
  localparam int STATUS_W   = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(NWORDS - 1);

  // request codes
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FREE,
    S_DONE
  } bsa_state_t;

  typedef struct packed {
    logic                 rd_en;
    logic [WORD_AW-1:0]   rd_addr;
    logic                 wr_en;
    logic [WORD_AW-1:0]   wr_addr;
    logic [WORD_BITS-1:0] wr_data;
  } bsa_mem_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [SLOT_OUT_W-1:0] slot_out;
    logic [COUNT_W-1:0]    in_use;
  } bsa_result_t;

  // bits of the last word that lie at or above ENTRIES
  function automatic logic [WORD_BITS-1:0] pad_mask();
    logic [WORD_BITS-1:0] m;
    m = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if ((NWORDS - 1) * WORD_BITS + i >= ENTRIES) m[i] = 1'b1;
    end
    return m;
  endfunction

  localparam logic [WORD_BITS-1:0] PAD_MASK = pad_mask();

  // index of the lowest set bit, zero when none
  function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) idx = BIT_W'(i);
    end
    return idx;
  endfunction

endpackage

// File: hdl/bsa_map_mem.sv
module bsa_map_mem (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bsa_pkg::bsa_mem_req_t         req,
  output logic [bsa_pkg::WORD_BITS-1:0] rd_data
);
  import bsa_pkg::*;

  logic [WORD_BITS-1:0] mem_r [NWORDS];
  logic [NWORDS-1:0]    valid_r;
  logic [WORD_BITS-1:0] rd_word_r;
  logic                 rd_valid_r;

  // word storage, no reset
  always_ff @(posedge clk) begin
    if (req.wr_en) mem_r[req.wr_addr] <= req.wr_data;
    if (req.rd_en) rd_word_r <= mem_r[req.rd_addr];
  end

  // per-word valid bits; a word never written reads as all free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (req.wr_en) valid_r[req.wr_addr] <= 1'b1;
      if (req.rd_en) rd_valid_r <= valid_r[req.rd_addr];
    end
  end

  assign rd_data = rd_valid_r ? rd_word_r : '0;

endmodule

// File: hdl/bsa_seq.sv
module bsa_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  logic                          req_func,
  input  logic [bsa_pkg::SLOT_IN_W-1:0] req_slot,
  output bsa_pkg::bsa_mem_req_t         mem_req,
  input  logic [bsa_pkg::WORD_BITS-1:0] mem_rd_data,
  output logic                          res_valid,
  input  logic                          res_ready,
  output bsa_pkg::bsa_result_t          res
);
  import bsa_pkg::*;

  bsa_state_t             state_r, state_nxt;
  logic [WORD_AW-1:0]     word_r, word_nxt;
  logic [BIT_W-1:0]       bit_r, bit_nxt;
  logic [STATUS_W-1:0]    status_r, status_nxt;
  logic [SLOT_OUT_W-1:0]  slot_r, slot_nxt;
  logic [COUNT_W-1:0]     count_r, count_nxt;

  logic                   accept;
  logic                   in_range;
  logic [WORD_BITS-1:0]   masked;
  logic [WORD_BITS-1:0]   free_bits;
  logic                   hit;
  logic [BIT_W-1:0]       hit_bit;
  logic [COUNT_W-1:0]     count_inc;
  logic [COUNT_W-1:0]     count_dec;

  assign accept   = req_valid && req_ready;
  assign in_range = int'(req_slot) < ENTRIES;

  // search of the word just read; padding bits count as taken
  assign masked    = mem_rd_data | ((word_r == LAST_WORD) ? PAD_MASK : '0);
  assign free_bits = ~masked;
  assign hit       = |free_bits;
  assign hit_bit   = lowest_set(free_bits);

  // saturating count updates
  assign count_inc = (count_r == COUNT_MAX) ? count_r : count_r + 1'b1;
  assign count_dec = (count_r == '0) ? count_r : count_r - 1'b1;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (req_func == FUNC_ALLOC) state_nxt = S_SCAN;
          else if (in_range)          state_nxt = S_FREE;
          else                        state_nxt = S_DONE;
        end
      end
      S_SCAN: begin
        if (hit || word_r == LAST_WORD) state_nxt = S_DONE;
      end
      S_FREE: state_nxt = S_DONE;
      S_DONE: begin
        if (res_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // memory requests, handshakes and datapath updates
  always_comb begin
    req_ready  = 1'b0;
    res_valid  = 1'b0;
    mem_req    = '0;
    word_nxt   = word_r;
    bit_nxt    = bit_r;
    status_nxt = status_r;
    slot_nxt   = slot_r;
    count_nxt  = count_r;
    unique case (state_r)
      S_IDLE: begin
        req_ready = 1'b1;
        if (accept) begin
          status_nxt = ST_OK;
          slot_nxt   = '0;
          if (req_func == FUNC_ALLOC) begin
            word_nxt        = '0;
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = '0;
          end else if (in_range) begin
            word_nxt        = WORD_AW'(req_slot >> BIT_W);
            bit_nxt         = BIT_W'(req_slot);
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = WORD_AW'(req_slot >> BIT_W);
          end else begin
            status_nxt = ST_RANGE;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = word_r;
          mem_req.wr_data = mem_rd_data | (WORD_BITS'(1) << hit_bit);
          slot_nxt        = SLOT_OUT_W'({word_r, hit_bit});
          count_nxt       = count_inc;
        end else if (word_r == LAST_WORD) begin
          status_nxt = ST_FULL;
        end else begin
          word_nxt        = word_r + 1'b1;
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = word_r + 1'b1;
        end
      end
      S_FREE: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = word_r;
        mem_req.wr_data = mem_rd_data & ~(WORD_BITS'(1) << bit_r);
        count_nxt       = count_dec;
      end
      S_DONE: res_valid = 1'b1;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    word_r   <= word_nxt;
    bit_r    <= bit_nxt;
    status_r <= status_nxt;
    slot_r   <= slot_nxt;
  end

  assign res.status   = status_r;
  assign res.slot_out = slot_r;
  assign res.in_use   = count_r;

endmodule

// File: hdl/bitmap_slot_allocator.sv
// bitmap slot allocator: hands out the lowest free slot and takes slots back
// input channel in_*: in_tuser = func (0 allocate, 1 free), in_tdata = slot_in
// result channel out_*: out_tuser = status, out_tdata = slot_out and in_use
// one request is worked at a time; in_tready drops from accept until the
// result has been handed to the output register
// allocate: accept, then one bitmap word read per cycle from a
// single-port-read map memory, up to 8 words, the set bit written back in the
// cycle that finds it, then the result passed on
// free: accept with the read, write back, hand over; out of range: accept, hand over
// the result appears on out_tvalid in the cycle after hand-over
// reset clears the per-word valid bits of the map at once, so every slot reads
// free, and clears the in-use count; no clearing pass is needed
// a stalled receiver holds the word in the output register; the next request
// is still accepted and worked, and waits in the sequencer until the output
// register frees up
module bitmap_slot_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] slot_in
  input  logic        in_tuser,   // [0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] slot_out, [16:8] in_use, [23:17] zero
  output logic [1:0]  out_tuser   // [1:0] status
);
  import bsa_pkg::*;

  `include "bitmap_slot_allocator_defines.svh"

  bsa_mem_req_t         mem_req;
  logic [WORD_BITS-1:0] mem_rd_data;
  logic                 res_valid;
  logic                 res_ready;
  bsa_result_t          res;
  logic                 out_valid_r, out_valid_nxt;
  bsa_result_t          out_res_r;

  bsa_map_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mem_req),
    .rd_data (mem_rd_data)
  );

  bsa_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (in_tvalid),
    .req_ready   (in_tready),
    .req_func    (in_tuser),
    .req_slot    (in_tdata),
    .mem_req     (mem_req),
    .mem_rd_data (mem_rd_data),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  // output register between sequencer and receiver
  assign res_ready     = !out_valid_r || out_tready;
  assign out_valid_nxt = res_valid || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) out_res_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = {7'd0, out_res_r.in_use, out_res_r.slot_out};

  // checks
  `BSA_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)
  `BSA_ASSERT_NOW(a_fail_no_slot, out_tvalid && out_tuser != ST_OK, out_tdata[7:0] == 8'd0)
  `BSA_ASSERT_NOW(a_count_bound, out_tvalid, int'(out_tdata[16:8]) <= ENTRIES)
  `BSA_ASSERT_NOW(a_no_result_overrun, res_valid && !res_ready, out_valid_r && !out_tready)

endmodule
